>>> design/cesu8_byte_stream_decoder_unit_assert.svh
// Assertion macros shared by the checker module of the CESU-8 decoder.
`ifndef CESU8_BYTE_STREAM_DECODER_UNIT_ASSERT_SVH
`define CESU8_BYTE_STREAM_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CBSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/cbsd_pkg.sv
// Types and constants shared by the CESU-8 byte stream decoder.
package cbsd_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_UNIT      = 2'd0;
    localparam logic [1:0] KIND_MALFORMED = 2'd1;
    localparam logic [1:0] KIND_TRUNCATED = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_REPLACE_MODE     = 1'b0;
    localparam logic CFG_REPLACEMENT_UNIT = 1'b1;

    localparam logic [15:0] REPLACEMENT_RESET = 16'hFFFD;

    // Result queue geometry.
    localparam int RES_QUEUE_DEPTH = 4;
    localparam int RES_PTR_W       = $clog2(RES_QUEUE_DEPTH);
    localparam int RES_CNT_W       = $clog2(RES_QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] code_unit;
        logic [1:0]  error_length;
        logic        last_of_run;
    } t_out_beat;

endpackage

>>> design/cesu8_byte_stream_decoder_unit.sv
// CESU-8 byte stream decoder: bytes in, UTF-16 code units and error reports out.
//
// One byte is taken per beat and decoded in the same cycle against the held
// sequence state; its results enter a four-entry result queue and appear on
// the output from the next cycle on. A byte is accepted every cycle as long
// as the queue has room for two results, so the input runs at one byte per
// clock while bytes give at most one result each and the output is not
// stalled. A byte that gives two results (an error followed by a re-read
// lead byte or a truncation) fills two beats of the single output port.
// Configuration writes take effect on the next byte.
module cesu8_byte_stream_decoder_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  cbsd_pkg::t_in_beat   i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output cbsd_pkg::t_out_beat  o_out_beat,
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_index,
    input  logic [15:0]          i_cfg_wr_data
);

    localparam int PTR_W = cbsd_pkg::RES_PTR_W;
    localparam int CNT_W = cbsd_pkg::RES_CNT_W;

    // Configuration.
    logic        r_replace_mode;
    logic [15:0] r_replacement_unit;

    // Open sequence state.
    logic [1:0] r_pending, n_pending;
    logic [1:0] r_exp_len, n_exp_len;
    logic [7:0] r_first,   n_first;
    logic [7:0] r_second,  n_second;

    // Result queue.
    cbsd_pkg::t_out_beat r_queue [cbsd_pkg::RES_QUEUE_DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]    r_count,  n_count;

    logic                in_fire;
    logic                out_fire;
    logic [1:0]          res_cnt;
    cbsd_pkg::t_out_beat res0;
    cbsd_pkg::t_out_beat res1;

    function automatic cbsd_pkg::t_out_beat make_beat(
        input logic [1:0]  kind,
        input logic [15:0] unit,
        input logic [1:0]  len,
        input logic        repl_mode,
        input logic [15:0] repl_unit
    );
        cbsd_pkg::t_out_beat beat;
        beat.result_kind  = kind;
        beat.code_unit    = unit;
        beat.error_length = len;
        beat.last_of_run  = 1'b0;
        if (kind != cbsd_pkg::KIND_UNIT) begin
            beat.code_unit = repl_mode ? repl_unit : 16'd0;
        end
        return beat;
    endfunction

    assign o_in_stall  = r_count > CNT_W'(cbsd_pkg::RES_QUEUE_DEPTH - 2);
    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_count != '0;
    assign out_fire    = o_out_valid && !i_out_stall;
    assign o_out_beat  = r_queue[r_rd_ptr];

    // Decode of one byte: up to two results and the new sequence state.
    always_comb begin
        logic [7:0]          b;
        logic                not_cont;
        logic                need_lead;
        cbsd_pkg::t_out_beat beat;
        logic [1:0]          held;

        b         = i_in_beat.data_byte;
        not_cont  = (b & 8'hC0) != 8'h80;
        need_lead = 1'b0;
        res_cnt   = 2'd0;
        res0      = '0;
        res1      = '0;
        beat      = '0;
        held      = 2'd0;
        n_pending = r_pending;
        n_exp_len = r_exp_len;
        n_first   = r_first;
        n_second  = r_second;

        if (r_pending == 2'd0) begin
            need_lead = 1'b1;
        end else if (r_pending == 2'd1 && r_exp_len == 2'd2) begin
            n_pending = 2'd0;
            n_exp_len = 2'd0;
            n_first   = 8'd0;
            n_second  = 8'd0;
            if (not_cont) begin
                res0      = make_beat(cbsd_pkg::KIND_MALFORMED, 16'd0, 2'd1,
                                      r_replace_mode, r_replacement_unit);
                res_cnt   = 2'd1;
                need_lead = 1'b1;
            end else begin
                res0    = make_beat(cbsd_pkg::KIND_UNIT, {5'd0, r_first[4:0], b[5:0]},
                                    2'd0, r_replace_mode, r_replacement_unit);
                res_cnt = 2'd1;
            end
        end else if (r_pending == 2'd1) begin
            // An E0 lead followed by 80-9F would be an overlong form.
            if ((r_first == 8'hE0 && (b & 8'hE0) == 8'h80) || not_cont) begin
                n_pending = 2'd0;
                n_exp_len = 2'd0;
                n_first   = 8'd0;
                n_second  = 8'd0;
                res0      = make_beat(cbsd_pkg::KIND_MALFORMED, 16'd0, 2'd1,
                                      r_replace_mode, r_replacement_unit);
                res_cnt   = 2'd1;
                need_lead = 1'b1;
            end else begin
                n_second  = b;
                n_pending = 2'd2;
            end
        end else begin
            n_pending = 2'd0;
            n_exp_len = 2'd0;
            n_first   = 8'd0;
            n_second  = 8'd0;
            if (not_cont) begin
                res0      = make_beat(cbsd_pkg::KIND_MALFORMED, 16'd0, 2'd2,
                                      r_replace_mode, r_replacement_unit);
                res_cnt   = 2'd1;
                need_lead = 1'b1;
            end else begin
                res0    = make_beat(cbsd_pkg::KIND_UNIT,
                                    {r_first[3:0], r_second[5:0], b[5:0]},
                                    2'd0, r_replace_mode, r_replacement_unit);
                res_cnt = 2'd1;
            end
        end

        // The byte read as a lead, either fresh or after a broken sequence.
        if (need_lead) begin
            if (b < 8'h80) begin
                beat = make_beat(cbsd_pkg::KIND_UNIT, {8'd0, b}, 2'd0,
                                 r_replace_mode, r_replacement_unit);
                if (res_cnt == 2'd0) res0 = beat; else res1 = beat;
                res_cnt = res_cnt + 2'd1;
            end else if (b inside {[8'hC2:8'hDF]}) begin
                n_first   = b;
                n_exp_len = 2'd2;
                n_pending = 2'd1;
            end else if (b inside {[8'hE0:8'hEF]}) begin
                n_first   = b;
                n_exp_len = 2'd3;
                n_pending = 2'd1;
            end else begin
                beat = make_beat(cbsd_pkg::KIND_MALFORMED, 16'd0, 2'd1,
                                 r_replace_mode, r_replacement_unit);
                if (res_cnt == 2'd0) res0 = beat; else res1 = beat;
                res_cnt = res_cnt + 2'd1;
            end
        end

        // A sequence still open at the final byte is reported as truncated.
        if (i_in_beat.end_of_input && n_pending != 2'd0) begin
            held      = n_pending;
            n_pending = 2'd0;
            n_exp_len = 2'd0;
            n_first   = 8'd0;
            n_second  = 8'd0;
            beat = make_beat(cbsd_pkg::KIND_TRUNCATED, 16'd0, held,
                             r_replace_mode, r_replacement_unit);
            if (res_cnt == 2'd0) res0 = beat; else res1 = beat;
            res_cnt = res_cnt + 2'd1;
        end

        if (res_cnt == 2'd1) begin
            res0.last_of_run = 1'b1;
        end else if (res_cnt == 2'd2) begin
            res1.last_of_run = 1'b1;
        end
    end

    always_comb begin
        logic [1:0] pushed;
        pushed   = in_fire ? res_cnt : 2'd0;
        n_wr_ptr = r_wr_ptr + PTR_W'(pushed);
        n_rd_ptr = r_rd_ptr + PTR_W'(out_fire);
        n_count  = r_count + CNT_W'(pushed) - CNT_W'(out_fire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_replace_mode     <= 1'b0;
            r_replacement_unit <= cbsd_pkg::REPLACEMENT_RESET;
            r_pending          <= 2'd0;
            r_exp_len          <= 2'd0;
            r_first            <= 8'd0;
            r_second           <= 8'd0;
            r_wr_ptr           <= '0;
            r_rd_ptr           <= '0;
            r_count            <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    cbsd_pkg::CFG_REPLACE_MODE:     r_replace_mode     <= i_cfg_wr_data[0];
                    cbsd_pkg::CFG_REPLACEMENT_UNIT: r_replacement_unit <= i_cfg_wr_data;
                    default: ;
                endcase
            end
            if (in_fire) begin
                r_pending <= n_pending;
                r_exp_len <= n_exp_len;
                r_first   <= n_first;
                r_second  <= n_second;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue payload carries no reset.
    always_ff @(posedge i_clk) begin
        if (in_fire && res_cnt != 2'd0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (in_fire && res_cnt == 2'd2) begin
            r_queue[r_wr_ptr + PTR_W'(1)] <= res1;
        end
    end

endmodule

>>> design/cbsd_checker.sv
// Port-level checker for the CESU-8 byte stream decoder, bound to the decoder module.
`include "cesu8_byte_stream_decoder_unit_assert.svh"

module cbsd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input cbsd_pkg::t_out_beat o_out_beat
);

    // A stalled result beat must stay offered and unchanged.
    `CBSD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_beat), "result beat changed while stalled")

    // Only the three defined result kinds ever leave the block.
    `CBSD_ASSERT_IMPL(a_kind_legal, i_clk, i_rst_n, o_out_valid, o_out_beat.result_kind == cbsd_pkg::KIND_UNIT || o_out_beat.result_kind == cbsd_pkg::KIND_MALFORMED || o_out_beat.result_kind == cbsd_pkg::KIND_TRUNCATED, "undefined result kind")

    // Decoded units consume no error bytes; every error consumes one or two.
    `CBSD_ASSERT_IMPL(a_len_match, i_clk, i_rst_n, o_out_valid, (o_out_beat.result_kind == cbsd_pkg::KIND_UNIT) == (o_out_beat.error_length == 2'd0), "error length does not match result kind")

    // With the result queue empty there is always room for a new byte.
    `CBSD_ASSERT_IMPL(a_no_idle_stall, i_clk, i_rst_n, !o_out_valid, !o_in_stall, "input stalled with no results pending")

endmodule

bind cesu8_byte_stream_decoder_unit cbsd_checker u_cbsd_checker (.*);
